@@ design/s2cd_pkg.sv @@
package s2cd_pkg;

  // field widths
  localparam int SECS_W  = 31;
  localparam int DAYS_W  = 15;
  localparam int TOD_W   = 17;
  localparam int YEAR_W  = 11;

  typedef logic [DAYS_W-1:0] days_t;
  typedef logic [TOD_W-1:0]  tod_t;

  // seconds -> days: (secs >> 7) * DAY_RECIP >> DAY_SHIFT, exact for 24-bit operands
  localparam int SECS_PER_DAY = 86400;
  localparam int DAY_RECIP    = 25451659;
  localparam int DAY_SHIFT    = 34;

  // time of day: (tod >> 4) / 225 and (ms >> 2) / 15 by reciprocal
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int HOUR_RECIP    = 4661;
  localparam int HOUR_SHIFT    = 20;
  localparam int MIN_RECIP     = 1093;
  localparam int MIN_SHIFT     = 14;

  // date: days counted from 1968-01-01 split into four-year cycles
  localparam int CYCLE_BASE_YEAR = 1968;
  localparam int CYCLE_OFFSET    = 731;
  localparam int DAYS_PER_CYCLE  = 1461;
  localparam int CYCLE_RECIP     = 22967;
  localparam int CYCLE_SHIFT     = 25;
  localparam int EPOCH_WEEKDAY   = 4;

  // stages inside each of the time and date sections
  localparam int SECT_STAGES = 5;

  // day of year on which a 0-based month starts
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) base = base + 9'd1;
    return base;
  endfunction

endpackage

@@ design/s2cd_tod.sv @@
module s2cd_tod import s2cd_pkg::*; (
  input  logic       clk,
  input  tod_t       tod,
  output logic [4:0] hour,
  output logic [5:0] minute,
  output logic [5:0] second
);

  logic [25:0] hour_prod;
  logic [20:0] min_prod;

  logic [4:0]  t3_hour;
  tod_t        t3_tod;
  logic [4:0]  t4_hour;
  logic [11:0] t4_ms;
  logic [4:0]  t5_hour;
  logic [5:0]  t5_min;
  logic [11:0] t5_ms;
  logic [4:0]  t6_hour;
  logic [5:0]  t6_min;
  logic [5:0]  t6_sec;

  assign hour_prod = 26'(tod[TOD_W-1:4]) * 26'(HOUR_RECIP);
  assign min_prod  = 21'(t4_ms[11:2]) * 21'(MIN_RECIP);

  // hour by reciprocal, then seconds within the hour, minute, second
  always_ff @(posedge clk) begin
    t3_hour <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
    t3_tod  <= tod;

    t4_hour <= t3_hour;
    t4_ms   <= 12'(t3_tod - TOD_W'(t3_hour) * TOD_W'(SECS_PER_HOUR));

    t5_hour <= t4_hour;
    t5_min  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
    t5_ms   <= t4_ms;

    t6_hour <= t5_hour;
    t6_min  <= t5_min;
    t6_sec  <= 6'(t5_ms - 12'(t5_min) * 12'(SECS_PER_MIN));

    hour    <= t6_hour;
    minute  <= t6_min;
    second  <= t6_sec;
  end

endmodule

@@ design/s2cd_date.sv @@
module s2cd_date import s2cd_pkg::*; (
  input  logic              clk,
  input  days_t             days,
  output logic [YEAR_W-1:0] year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [2:0]        weekday
);

  days_t       shifted;
  logic [29:0] cycle_prod;
  days_t       wd_sum_in;
  logic [5:0]  wd_fold1;
  logic [3:0]  wd_fold2;
  logic [2:0]  wd_next;
  logic [1:0]  yic;
  logic [8:0]  left_next;
  logic [3:0]  mon_cnt;

  logic [4:0]        d3_q4;
  days_t             d3_shifted;
  logic [2:0]        d3_wd;
  logic [4:0]        d4_q4;
  logic [10:0]       d4_r;
  logic [2:0]        d4_wd;
  logic [YEAR_W-1:0] d5_year;
  logic [8:0]        d5_left;
  logic              d5_leap;
  logic [2:0]        d5_wd;
  logic [YEAR_W-1:0] d6_year;
  logic [8:0]        d6_left;
  logic              d6_leap;
  logic [3:0]        d6_mon;
  logic [2:0]        d6_wd;

  // cycle count by reciprocal
  assign shifted    = DAYS_W'(days + DAYS_W'(CYCLE_OFFSET));
  assign cycle_prod = 30'(shifted) * 30'(CYCLE_RECIP);

  // weekday: 8 is 1 mod 7, so fold octal digits twice and correct once
  always_comb begin
    wd_sum_in = DAYS_W'(days + DAYS_W'(EPOCH_WEEKDAY));
    wd_fold1  = 6'(wd_sum_in[2:0]) + 6'(wd_sum_in[5:3]) + 6'(wd_sum_in[8:6])
              + 6'(wd_sum_in[11:9]) + 6'(wd_sum_in[14:12]);
    wd_fold2  = 4'(wd_fold1[2:0]) + 4'(wd_fold1[5:3]);
    wd_next   = (wd_fold2 >= 4'd7) ? 3'(wd_fold2 - 4'd7) : wd_fold2[2:0];
  end

  // year within the cycle; the cycle opens with a leap year
  always_comb begin
    priority if (d4_r < 11'd366) begin
      yic       = 2'd0;
      left_next = 9'(d4_r);
    end else if (d4_r < 11'd731) begin
      yic       = 2'd1;
      left_next = 9'(d4_r - 11'd366);
    end else if (d4_r < 11'd1096) begin
      yic       = 2'd2;
      left_next = 9'(d4_r - 11'd731);
    end else begin
      yic       = 2'd3;
      left_next = 9'(d4_r - 11'd1096);
    end
  end

  // month: number of later month starts already reached
  always_comb begin
    mon_cnt = '0;
    for (int k = 1; k < 12; k++) begin
      if (d5_left >= month_start(4'(k), d5_leap)) mon_cnt = mon_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    d3_q4      <= cycle_prod[CYCLE_SHIFT+4:CYCLE_SHIFT];
    d3_shifted <= shifted;
    d3_wd      <= wd_next;

    d4_q4      <= d3_q4;
    d4_r       <= 11'(d3_shifted - DAYS_W'(d3_q4) * DAYS_W'(DAYS_PER_CYCLE));
    d4_wd      <= d3_wd;

    d5_year    <= YEAR_W'(CYCLE_BASE_YEAR) + YEAR_W'({d4_q4, 2'b00}) + YEAR_W'(yic);
    d5_left    <= left_next;
    d5_leap    <= (yic == 2'd0);
    d5_wd      <= d4_wd;

    d6_year    <= d5_year;
    d6_left    <= d5_left;
    d6_leap    <= d5_leap;
    d6_mon     <= mon_cnt;
    d6_wd      <= d5_wd;

    year         <= d6_year;
    month        <= d6_mon + 4'd1;
    day_of_month <= 5'(d6_left - month_start(d6_mon, d6_leap) + 9'd1);
    weekday      <= d6_wd;
  end

endmodule

@@ design/seconds_to_calendar_date.sv @@
// Channel  Handshake              Ports
// input    start & !busy          epoch_seconds
// result   done (one cycle)       hour minute second year month day_of_month weekday
//
// One word enters per cycle while busy is low; its result shows on done once it
// has passed the pipeline: two stages for the day split, then five in the
// parallel time-of-day and date sections.
// rst is synchronous; it clears the valid chain and holds busy high for one
// cycle after it. The receiver cannot stall, so nothing ever backs up.
module seconds_to_calendar_date import s2cd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SECS_W-1:0] epoch_seconds,
  output logic              busy,
  output logic              done,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second,
  output logic [YEAR_W-1:0] year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [2:0]        weekday
);

  localparam int LAT = SECT_STAGES + 2;

  logic              accept;
  logic [LAT-1:0]    vld;
  logic [48:0]       s1_prod;
  logic [SECS_W-1:0] s1_secs;
  days_t             s1_days;
  days_t             s2_days;
  tod_t              s2_tod;

  assign accept  = start && !busy;
  assign done    = vld[LAT-1];
  assign s1_days = s1_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];

  // valid chain and reset guard
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      busy <= 1'b1;
    end else begin
      vld  <= {vld[LAT-2:0], accept};
      busy <= 1'b0;
    end
  end

  // days by reciprocal of 86400 / 128, then seconds within the day
  always_ff @(posedge clk) begin
    s1_prod <= 49'(epoch_seconds[SECS_W-1:7]) * 49'(DAY_RECIP);
    s1_secs <= epoch_seconds;
    s2_days <= s1_days;
    s2_tod  <= TOD_W'(s1_secs - SECS_W'(s1_days) * SECS_W'(SECS_PER_DAY));
  end

  s2cd_tod u_tod (
    .clk    (clk),
    .tod    (s2_tod),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  s2cd_date u_date (
    .clk          (clk),
    .days         (s2_days),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  // every result traces back to an accepted input word
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching input word");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
              && weekday <= 3'd6 && year >= 11'd1970 && year <= 11'd2038))
    else $error("date out of range");

endmodule
